// ===== rtl/core/color_temperature_to_rgb_defines.svh =====
// Assertion macros shared by the colour temperature converter modules.
// Each user module must provide signals named clock and reset.
`ifndef COLOR_TEMPERATURE_TO_RGB_DEFINES_SVH
`define COLOR_TEMPERATURE_TO_RGB_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define CTR_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("invariant violated");

// A trigger that must be followed by a condition in the next cycle.
`define CTR_ASSERT_NEXT(label, trig, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("next-cycle check violated");

`endif

// ===== rtl/core/ctr_pkg.sv =====
// Package for the colour temperature to RGB converter: constants, types and
// the elaboration-time helpers for the logarithm and power pipelines.
// Depends on nothing.
package ctr_pkg;

   // Fixed-point layout of the internal arithmetic.
   localparam int QBITS             = 28;
   localparam int FRAC_BITS_DEFAULT = 12;
   localparam int LEVEL_W           = 13;
   localparam int LOG_STEPS         = 28;
   localparam int EXP_STEPS         = 28;

   // Temperature thresholds in kelvin.
   localparam logic [15:0] K_MIN         = 16'd1000;
   localparam logic [15:0] K_MAX         = 16'd40000;
   localparam logic [15:0] K_SPLIT       = 16'd6600;
   localparam logic [15:0] K_BLUE_ZERO   = 16'd1900;
   localparam logic [15:0] K_POWER_SHIFT = 16'd6000;
   localparam logic [15:0] K_BLUE_SHIFT  = 16'd1000;

   // Curve coefficients in Q28.
   localparam logic [31:0] LN2_Q28 = 32'd186065280;
   localparam logic [31:0] GA_Q28  = 32'd104711726;
   localparam logic [31:0] GB_Q28  = 32'd169608646;
   localparam logic [31:0] RA_Q28  = 32'd347069915;
   localparam logic [31:0] RE_Q28  = 32'd35756880;
   localparam logic [31:0] HA_Q28  = 32'd303302769;
   localparam logic [31:0] HE_Q28  = 32'd20270863;
   localparam logic [31:0] BA_Q28  = 32'd145815962;
   localparam logic [31:0] BB_Q28  = 32'd321117012;

   localparam logic signed [33:0] ONE_Q   = 34'sd268435456;
   localparam logic [31:0]        TWO_Q28 = 32'd536870912;

   // Control flags that travel alongside each request.
   typedef struct packed {
      logic valid;
      logic low_temp;
      logic blue_full;
      logic blue_zero;
   } ctrl_type;

   // One result triple.
   typedef struct packed {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
   } levels_type;

   // Floor square root, used only at elaboration to build the power factors.
   function automatic logic [63:0] ctr_isqrt64(input logic [63:0] x_arg);
      logic [63:0] x;
      logic [63:0] res;
      logic [63:0] bv;
      x   = x_arg;
      res = '0;
      bv  = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (x >= res + bv) begin
            x   = x - (res + bv);
            res = (res >> 1) + bv;
         end else begin
            res = res >> 1;
         end
         bv = bv >> 2;
      end
      return res;
   endfunction

   // Factor 2^(2^-(step+1)) in Q30, by repeated floor square roots from 2.0.
   function automatic logic [30:0] ctr_exp2_factor(input int step);
      logic [63:0] s;
      s = 64'd1 << 31;
      for (int i = 0; i <= step; i++) begin
         s = ctr_isqrt64(s << 30);
      end
      return s[30:0];
   endfunction

   // Base-two logarithm in Q28 by repeated squaring, for constants only.
   function automatic logic [31:0] ctr_log2_q28(input logic [15:0] n);
      logic [15:0] nn;
      logic [3:0]  p;
      logic [63:0] m;
      logic [27:0] frac;
      nn = (n == 16'd0) ? 16'd1 : n;
      p  = '0;
      for (int i = 0; i < 16; i++) begin
         if (nn[i]) p = 4'(i);
      end
      m    = 64'(nn) << (30 - int'(p));
      frac = '0;
      for (int k = QBITS - 1; k >= 0; k--) begin
         m = (m * m) >> 30;
         if (m >= (64'd1 << 31)) begin
            m       = m >> 1;
            frac[k] = 1'b1;
         end
      end
      return {p, frac};
   endfunction

   localparam logic [31:0] LOG2_100_Q28 = ctr_log2_q28(16'd100);

   // Clamp a Q28 value to [0, 1.0] and round half up to the output format.
   function automatic logic [LEVEL_W-1:0] ctr_to_level(input logic signed [33:0] q,
                                                      input int frac_bits);
      logic [29:0] c;
      logic [29:0] r;
      if (q < 0) begin
         c = '0;
      end else if (q > ONE_Q) begin
         c = 30'(ONE_Q);
      end else begin
         c = q[29:0];
      end
      r = (c + (30'd1 << (QBITS - frac_bits - 1))) >> (QBITS - frac_bits);
      return r[LEVEL_W-1:0];
   endfunction

endpackage

// ===== rtl/core/ctr_log2_pipe.sv =====
// Pipelined base-two logarithm of a 16-bit integer, result in Q28.
// One normalise stage, then one squaring stage per fraction bit.
// Depends on ctr_pkg.
module ctr_log2_pipe
   import ctr_pkg::*;
(
   input  logic        clock,
   input  logic        enable,
   input  logic [15:0] operand,
   output logic [31:0] log2_value
);

   logic [15:0] norm_n;
   logic [3:0]  norm_p;
   logic [30:0] norm_m;
   logic [30:0] norm_m_ff;
   logic [3:0]  norm_p_ff;

   logic [30:0] m_stage    [LOG_STEPS-1];
   logic [27:0] frac_stage [LOG_STEPS];
   logic [3:0]  p_stage    [LOG_STEPS];

   // Find the top set bit and left-align the mantissa to [1,2) in Q30.
   always_comb begin
      norm_n = (operand == 16'd0) ? 16'd1 : operand;
      norm_p = '0;
      for (int i = 0; i < 16; i++) begin
         if (norm_n[i]) norm_p = 4'(i);
      end
      norm_m = 31'(norm_n) << (5'd30 - {1'b0, norm_p});
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         norm_m_ff <= norm_m;
         norm_p_ff <= norm_p;
      end
   end

   // Each stage squares the mantissa and yields one fraction bit.
   for (genvar s = 0; s < LOG_STEPS; s++) begin : g_step
      logic [30:0] m_prev;
      logic [27:0] frac_prev;
      logic [3:0]  p_prev;
      logic [61:0] square;
      logic [31:0] scaled;
      logic [27:0] frac_in;
      logic [27:0] frac_ff;
      logic [3:0]  p_ff;

      if (s == 0) begin : g_first
         assign m_prev    = norm_m_ff;
         assign frac_prev = '0;
         assign p_prev    = norm_p_ff;
      end else begin : g_next
         assign m_prev    = m_stage[s-1];
         assign frac_prev = frac_stage[s-1];
         assign p_prev    = p_stage[s-1];
      end

      assign square  = 62'(m_prev) * 62'(m_prev);
      assign scaled  = square[61:30];
      assign frac_in = {frac_prev[26:0], scaled[31]};

      always_ff @(posedge clock) begin
         if (enable) begin
            frac_ff <= frac_in;
            p_ff    <= p_prev;
         end
      end

      assign frac_stage[s] = frac_ff;
      assign p_stage[s]    = p_ff;

      // The last stage needs no mantissa of its own.
      if (s < LOG_STEPS - 1) begin : g_mant
         logic [30:0] m_in;
         logic [30:0] m_ff;
         assign m_in = scaled[31] ? scaled[31:1] : scaled[30:0];
         always_ff @(posedge clock) begin
            if (enable) begin
               m_ff <= m_in;
            end
         end
         assign m_stage[s] = m_ff;
      end
   end

   assign log2_value = {p_stage[LOG_STEPS-1], frac_stage[LOG_STEPS-1]};

endmodule

// ===== rtl/core/ctr_exp2_pipe.sv =====
// Pipelined power of two for a Q28 exponent in [0,4), result in Q30.
// One stage per fraction bit, each multiplying by a constant root of two.
// Depends on ctr_pkg.
module ctr_exp2_pipe
   import ctr_pkg::*;
(
   input  logic        clock,
   input  logic        enable,
   input  logic [29:0] exponent,
   output logic [33:0] power
);

   logic [30:0] r_stage    [EXP_STEPS];
   logic [1:0]  ip_stage   [EXP_STEPS];
   logic [27:0] bits_stage [EXP_STEPS-1];

   // Stage j looks at the fraction bit of weight 2^-(j+1).
   for (genvar j = 0; j < EXP_STEPS; j++) begin : g_step
      localparam logic [30:0] FACTOR = ctr_exp2_factor(j);
      logic [30:0] r_prev;
      logic [27:0] bits_prev;
      logic [1:0]  ip_prev;
      logic [61:0] product;
      logic [30:0] r_in;
      logic [30:0] r_ff;
      logic [1:0]  ip_ff;

      if (j == 0) begin : g_first
         assign r_prev    = 31'd1 << 30;
         assign bits_prev = exponent[27:0];
         assign ip_prev   = exponent[29:28];
      end else begin : g_next
         assign r_prev    = r_stage[j-1];
         assign bits_prev = bits_stage[j-1];
         assign ip_prev   = ip_stage[j-1];
      end

      assign product = 62'(r_prev) * 62'(FACTOR);
      assign r_in    = bits_prev[27] ? product[60:30] : r_prev;

      always_ff @(posedge clock) begin
         if (enable) begin
            r_ff  <= r_in;
            ip_ff <= ip_prev;
         end
      end

      assign r_stage[j]  = r_ff;
      assign ip_stage[j] = ip_ff;

      // Remaining fraction bits move up one place per stage.
      if (j < EXP_STEPS - 1) begin : g_bits
         logic [27:0] bits_in;
         logic [27:0] bits_ff;
         assign bits_in = {bits_prev[26:0], 1'b0};
         always_ff @(posedge clock) begin
            if (enable) begin
               bits_ff <= bits_in;
            end
         end
         assign bits_stage[j] = bits_ff;
      end
   end

   // Apply the integer part of the exponent.
   assign power = 34'(r_stage[EXP_STEPS-1]) << ip_stage[EXP_STEPS-1];

endmodule

// ===== rtl/core/ctr_out_buf.sv =====
// Output register with a one-entry skid stage for the result channel.
// Depends on ctr_pkg and the shared assertion macros.
`include "color_temperature_to_rgb_defines.svh"

module ctr_out_buf
   import ctr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_valid,
   input  levels_type in_levels,
   output logic       in_ready,
   output logic       out_valid,
   output levels_type out_levels,
   input  logic       out_ready
);

   logic       out_valid_ff;
   logic       out_valid_in;
   logic       skid_valid_ff;
   logic       skid_valid_in;
   levels_type out_data_ff;
   levels_type out_data_in;
   levels_type skid_data_ff;
   levels_type skid_data_in;

   // The pipeline may advance whenever the skid entry is free.
   assign in_ready = !skid_valid_ff;

   // Refill the output register when it empties; park a request when it stalls.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = in_valid;
            out_data_in  = in_levels;
         end
      end else if (in_valid && !skid_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_levels;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid  = out_valid_ff;
   assign out_levels = out_data_ff;

   // The skid entry is only ever filled behind a held output.
   `CTR_ASSERT_ALWAYS(a_skid_behind_out, !skid_valid_ff || out_valid_ff)
   `CTR_ASSERT_NEXT(a_stall_fills_skid, out_valid_ff && !out_ready && in_valid && !skid_valid_ff, skid_valid_ff)
   `CTR_ASSERT_NEXT(a_skid_drains, skid_valid_ff && out_ready, out_valid_ff && !skid_valid_ff)

endmodule

// ===== rtl/core/color_temperature_to_rgb.sv =====
// Colour temperature to RGB converter, top level.
// Depends on ctr_pkg, ctr_log2_pipe, ctr_exp2_pipe, ctr_out_buf and the macros.
//
// A request carries a temperature in kelvin on req_temperature_kelvin and is
// taken when req_valid and req_ready are both high. Each request yields one
// result on rsp_red_level, rsp_green_level and rsp_blue_level, unsigned with
// FRAC_BITS fractional bits, taken when rsp_valid and rsp_ready are high.
// Results leave in request order. A new request is taken every cycle while
// req_ready is high; the latency is set by the 29-stage logarithm pipeline
// and the 28-stage power-of-two pipeline, one squaring or one multiplication
// per stage.
// If the receiver stalls, the output register holds its result and one more
// result is parked in a skid entry; req_ready then drops and the whole
// pipeline holds still until the skid entry drains.
// Reset is synchronous and clears every valid flag; the block takes requests
// in the first cycle after reset.
`include "color_temperature_to_rgb_defines.svh"

module color_temperature_to_rgb
   import ctr_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [15:0]        req_temperature_kelvin,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [LEVEL_W-1:0] rsp_red_level,
   output logic [LEVEL_W-1:0] rsp_green_level,
   output logic [LEVEL_W-1:0] rsp_blue_level
);

   localparam int LOG_LAT = LOG_STEPS + 1;

   logic advance;

   // Control flags down the pipeline.
   ctrl_type ctrl_s0_in;
   ctrl_type ctrl_s0_ff;
   ctrl_type ctrl_log_ff [LOG_LAT];
   ctrl_type ctrl_d_ff;
   ctrl_type ctrl_m1_ff;
   ctrl_type ctrl_m2_ff;
   ctrl_type ctrl_exp_ff [EXP_STEPS];
   ctrl_type ctrl_m3_ff;

   // Datapath.
   logic [15:0] k_clamp;
   logic [15:0] n0_in;
   logic [15:0] n1_in;
   logic [15:0] n0_ff;
   logic [15:0] n1_ff;
   logic [31:0] log0;
   logic [31:0] log1;
   logic [31:0] d0_in;
   logic [31:0] d1_in;
   logic [31:0] d0_ff;
   logic [31:0] d1_ff;
   logic [63:0] ln0_prod;
   logic [63:0] ln1_prod;
   logic [63:0] zr_prod;
   logic [63:0] zg_prod;
   logic [31:0] ln0_ff;
   logic [31:0] ln1_ff;
   logic [31:0] zr_ff;
   logic [31:0] zg_ff;
   logic [63:0] ga_prod;
   logic [63:0] ba_prod;
   logic signed [33:0] green_a_in;
   logic signed [33:0] blue_a_in;
   logic [29:0] u_red_in;
   logic [29:0] u_green_in;
   logic signed [33:0] green_a_ff;
   logic signed [33:0] blue_a_ff;
   logic [29:0] u_red_ff;
   logic [29:0] u_green_ff;
   logic signed [33:0] green_a_dly_ff [EXP_STEPS];
   logic signed [33:0] blue_a_dly_ff  [EXP_STEPS];
   logic [33:0] pow_red;
   logic [33:0] pow_green;
   logic [63:0] red_b_prod;
   logic [63:0] green_b_prod;
   logic [30:0] red_b_ff;
   logic [30:0] green_b_ff;
   logic signed [33:0] green_a_m3_ff;
   logic signed [33:0] blue_a_m3_ff;
   logic signed [33:0] red_q;
   logic signed [33:0] green_q;
   logic signed [33:0] blue_q;
   levels_type  levels;
   levels_type  rsp_levels;
   logic        buf_in_ready;

   assign advance   = buf_in_ready;
   assign req_ready = advance;

   // Clamp the temperature and pick the operands of the two logarithms.
   always_comb begin
      if (req_temperature_kelvin < K_MIN) begin
         k_clamp = K_MIN;
      end else if (req_temperature_kelvin > K_MAX) begin
         k_clamp = K_MAX;
      end else begin
         k_clamp = req_temperature_kelvin;
      end
      ctrl_s0_in.valid     = req_valid;
      ctrl_s0_in.low_temp  = (k_clamp <= K_SPLIT);
      ctrl_s0_in.blue_full = (k_clamp >= K_SPLIT);
      ctrl_s0_in.blue_zero = (k_clamp <= K_BLUE_ZERO);
      n0_in = ctrl_s0_in.low_temp ? k_clamp : k_clamp - K_POWER_SHIFT;
      n1_in = k_clamp - K_BLUE_SHIFT;
   end

   ctr_log2_pipe u_log_main (
      .clock      (clock),
      .enable     (advance),
      .operand    (n0_ff),
      .log2_value (log0)
   );

   ctr_log2_pipe u_log_blue (
      .clock      (clock),
      .enable     (advance),
      .operand    (n1_ff),
      .log2_value (log1)
   );

   // Logarithm of the value over one hundred, never below zero.
   assign d0_in = (log0 >= LOG2_100_Q28) ? log0 - LOG2_100_Q28 : '0;
   assign d1_in = (log1 >= LOG2_100_Q28) ? log1 - LOG2_100_Q28 : '0;

   // Natural logarithms and the power-curve exponents.
   assign ln0_prod = 64'(d0_ff) * 64'(LN2_Q28);
   assign ln1_prod = 64'(d1_ff) * 64'(LN2_Q28);
   assign zr_prod  = 64'(d0_ff) * 64'(RE_Q28);
   assign zg_prod  = 64'(d0_ff) * 64'(HE_Q28);

   // Logarithmic curves for green and blue; exponents for the power curves.
   assign ga_prod    = 64'(GA_Q28) * 64'(ln0_ff);
   assign ba_prod    = 64'(BA_Q28) * 64'(ln1_ff);
   assign green_a_in = $signed({3'b000, ga_prod[58:28]}) - $signed(34'(GB_Q28));
   assign blue_a_in  = $signed({2'b00, ba_prod[59:28]}) - $signed(34'(BB_Q28));
   assign u_red_in   = 30'(TWO_Q28 - ((zr_ff > TWO_Q28) ? TWO_Q28 : zr_ff));
   assign u_green_in = 30'(TWO_Q28 - ((zg_ff > TWO_Q28) ? TWO_Q28 : zg_ff));

   ctr_exp2_pipe u_exp_red (
      .clock    (clock),
      .enable   (advance),
      .exponent (u_red_ff),
      .power    (pow_red)
   );

   ctr_exp2_pipe u_exp_green (
      .clock    (clock),
      .enable   (advance),
      .exponent (u_green_ff),
      .power    (pow_green)
   );

   // Scale the powers by their coefficients.
   assign red_b_prod   = 64'(RA_Q28) * 64'(pow_red[33:2]);
   assign green_b_prod = 64'(HA_Q28) * 64'(pow_green[33:2]);

   // Choose each channel's curve and convert to the output format.
   always_comb begin
      red_q   = ctrl_m3_ff.low_temp ? ONE_Q : $signed({3'b000, red_b_ff});
      green_q = ctrl_m3_ff.low_temp ? green_a_m3_ff : $signed({3'b000, green_b_ff});
      if (ctrl_m3_ff.blue_full) begin
         blue_q = ONE_Q;
      end else if (ctrl_m3_ff.blue_zero) begin
         blue_q = '0;
      end else begin
         blue_q = blue_a_m3_ff;
      end
      levels.red   = ctr_to_level(red_q, FRAC_BITS);
      levels.green = ctr_to_level(green_q, FRAC_BITS);
      levels.blue  = ctr_to_level(blue_q, FRAC_BITS);
   end

   // Control line, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_s0_ff <= '0;
         for (int i = 0; i < LOG_LAT; i++) ctrl_log_ff[i] <= '0;
         ctrl_d_ff  <= '0;
         ctrl_m1_ff <= '0;
         ctrl_m2_ff <= '0;
         for (int i = 0; i < EXP_STEPS; i++) ctrl_exp_ff[i] <= '0;
         ctrl_m3_ff <= '0;
      end else if (advance) begin
         ctrl_s0_ff     <= ctrl_s0_in;
         ctrl_log_ff[0] <= ctrl_s0_ff;
         for (int i = 1; i < LOG_LAT; i++) ctrl_log_ff[i] <= ctrl_log_ff[i-1];
         ctrl_d_ff      <= ctrl_log_ff[LOG_LAT-1];
         ctrl_m1_ff     <= ctrl_d_ff;
         ctrl_m2_ff     <= ctrl_m1_ff;
         ctrl_exp_ff[0] <= ctrl_m2_ff;
         for (int i = 1; i < EXP_STEPS; i++) ctrl_exp_ff[i] <= ctrl_exp_ff[i-1];
         ctrl_m3_ff     <= ctrl_exp_ff[EXP_STEPS-1];
      end
   end

   // Datapath registers, moving in step with the control line.
   always_ff @(posedge clock) begin
      if (advance) begin
         n0_ff      <= n0_in;
         n1_ff      <= n1_in;
         d0_ff      <= d0_in;
         d1_ff      <= d1_in;
         ln0_ff     <= ln0_prod[59:28];
         ln1_ff     <= ln1_prod[59:28];
         zr_ff      <= zr_prod[59:28];
         zg_ff      <= zg_prod[59:28];
         green_a_ff <= green_a_in;
         blue_a_ff  <= blue_a_in;
         u_red_ff   <= u_red_in;
         u_green_ff <= u_green_in;
         green_a_dly_ff[0] <= green_a_ff;
         blue_a_dly_ff[0]  <= blue_a_ff;
         for (int i = 1; i < EXP_STEPS; i++) begin
            green_a_dly_ff[i] <= green_a_dly_ff[i-1];
            blue_a_dly_ff[i]  <= blue_a_dly_ff[i-1];
         end
         red_b_ff      <= red_b_prod[60:30];
         green_b_ff    <= green_b_prod[60:30];
         green_a_m3_ff <= green_a_dly_ff[EXP_STEPS-1];
         blue_a_m3_ff  <= blue_a_dly_ff[EXP_STEPS-1];
      end
   end

   ctr_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (ctrl_m3_ff.valid),
      .in_levels  (levels),
      .in_ready   (buf_in_ready),
      .out_valid  (rsp_valid),
      .out_levels (rsp_levels),
      .out_ready  (rsp_ready)
   );

   assign rsp_red_level   = rsp_levels.red;
   assign rsp_green_level = rsp_levels.green;
   assign rsp_blue_level  = rsp_levels.blue;

   // Above the split temperature blue is always full, and never both full and zero.
   `CTR_ASSERT_ALWAYS(a_high_temp_blue_full, !ctrl_s0_ff.valid || ctrl_s0_ff.low_temp || ctrl_s0_ff.blue_full)
   `CTR_ASSERT_ALWAYS(a_blue_flags_exclusive, !(ctrl_s0_ff.blue_full && ctrl_s0_ff.blue_zero))
   // A held pipeline keeps its last stage unchanged.
   `CTR_ASSERT_NEXT(a_stall_holds_tail, !advance, $stable(ctrl_m3_ff))

endmodule
